>>> hw/rtl/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// shared constants, codes and types of the five-stage pipeline core
// ----------------------------------------------------------------------------
package fsp_pkg;

    // data memory depth, a power of two
    localparam int DATA_WORDS = 256;
    localparam int DW_AW      = $clog2(DATA_WORDS);

    localparam logic [5:0]  OP_RTYPE  = 6'd0;
    localparam logic [5:0]  OP_BEQ    = 6'd4;
    localparam logic [5:0]  OP_LW     = 6'd35;
    localparam logic [5:0]  OP_SW     = 6'd43;
    localparam logic [5:0]  FUNCT_ADD = 6'd32;
    localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ACT_STEP   = 3'd0,
        ACT_WR_REG = 3'd1,
        ACT_WR_MEM = 3'd2,
        ACT_RD_REG = 3'd3,
        ACT_RD_MEM = 3'd4
    } t_action;

    typedef struct packed {
        logic             wr_en;
        logic [DW_AW-1:0] wr_word;
        logic [31:0]      wr_data;
        logic             pf_load;
        logic [DW_AW-1:0] pf_word;
        logic             rb_en;
        logic [DW_AW-1:0] rb_word;
    } t_dmem_req;

    typedef struct packed {
        logic rw;
        logic rd;
        logic wr;
        logic imm;
        logic add;
        logic br;
    } t_ctrl;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

>>> hw/rtl/fsp_dmem.sv
// ----------------------------------------------------------------------------
// fsp_dmem
// data memory with clearing pass, readback port and load prefetch port
// ----------------------------------------------------------------------------
module fsp_dmem
    import fsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dmem_req   i_req,
    output logic [31:0] o_pf_data,
    output logic [31:0] o_rb_data,
    output logic        o_busy
);

    logic [31:0]      mem [DATA_WORDS];
    logic             r_clr_busy;
    logic [DW_AW-1:0] r_clr_word;
    logic [DW_AW-1:0] r_pf_word;
    logic [DW_AW-1:0] n_pf_word;
    logic [31:0]      r_pf_data;
    logic [31:0]      r_rb_data;

    assign n_pf_word = i_req.pf_load ? i_req.pf_word : r_pf_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_word <= '0;
        end else if (r_clr_busy) begin
            r_clr_word <= r_clr_word + 1'b1;
            if (r_clr_word == DW_AW'(DATA_WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_word] <= '0;
        end else if (i_req.wr_en) begin
            mem[i_req.wr_word] <= i_req.wr_data;
        end
    end

    // prefetch register tracks the word the memory stage will load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pf_word <= '0;
            r_pf_data <= '0;
        end else begin
            r_pf_word <= n_pf_word;
            if (r_clr_busy) begin
                r_pf_data <= '0;
            end else if (i_req.wr_en && i_req.wr_word == n_pf_word) begin
                r_pf_data <= i_req.wr_data;
            end else begin
                r_pf_data <= mem[n_pf_word];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rb_en) begin
            r_rb_data <= mem[i_req.rb_word];
        end
    end

    assign o_pf_data = r_pf_data;
    assign o_rb_data = r_rb_data;
    assign o_busy    = r_clr_busy;

endmodule

>>> hw/rtl/five_stage_pipeline_core_unit.sv
// ----------------------------------------------------------------------------
// five_stage_pipeline_core_unit
// five-stage in-order core (add, sub, lw, sw, beq) advanced by each step beat
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | i_valid / o_ready  | i_action, i_instr_word, i_index, i_value
//  output   | o_valid / i_ready  | o_fetch_address .. o_finished (11 fields)
//
//  one beat per cycle while o_ready is high: each beat updates the core state
//  when accepted and its result sits in the output register on the next cycle
//  the output register frees the input side: a beat is taken whenever the
//  result slot is empty or being drained, outside the clearing pass
//  after reset a clearing pass zeroes the data memory with o_ready low; the
//  register file clears at once
//  data memory loads use a prefetch register filled when the address enters
//  the memory stage
// ----------------------------------------------------------------------------
module five_stage_pipeline_core_unit
    import fsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_instr_word,
    input  logic [7:0]  i_index,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_fetch_address,
    output logic [31:0] o_read_value,
    output logic        o_wb_valid,
    output logic [4:0]  o_wb_register,
    output logic [31:0] o_wb_value,
    output logic        o_store_valid,
    output logic [31:0] o_store_address,
    output logic [31:0] o_store_value,
    output logic        o_stalled,
    output logic        o_flushed,
    output logic        o_finished
);

    // core state
    logic [31:0] r_pc;
    logic        r_fetch_en;
    logic [31:0] r_if_instr;
    logic        r_if_valid;
    logic        r_ex_valid;
    logic [4:0]  r_ex_rs, r_ex_rt, r_ex_dest;
    logic [15:0] r_ex_imm;
    logic [31:0] r_ex_a, r_ex_b;
    t_ctrl       r_ex_ctrl;
    logic        r_xm_valid;
    logic [31:0] r_xm_alu, r_xm_data;
    logic [4:0]  r_xm_dest, r_xm_rt;
    logic        r_xm_rw, r_xm_rd, r_xm_wr;
    logic        r_mw_valid, r_mw_rw;
    logic [4:0]  r_mw_dest;
    logic [31:0] r_mw_value;
    logic [31:0] r_rf [32];

    // result register
    logic        r_o_valid;
    logic [31:0] r_o_pc, r_o_read;
    logic        r_o_rd_mem;
    logic        r_o_wbv;
    logic [4:0]  r_o_wbr;
    logic [31:0] r_o_wbd;
    logic        r_o_stv;
    logic [31:0] r_o_sta, r_o_std;
    logic        r_o_stall, r_o_flush, r_o_fin;

    t_action     act;
    logic        accept, step, dm_busy;
    t_dmem_req   dm_req;
    logic [31:0] pf_data, rb_data;

    assign act    = t_action'(i_action);
    assign accept = i_valid && o_ready;
    assign step   = accept && (act == ACT_STEP);
    assign o_ready = !dm_busy && (!r_o_valid || i_ready);

    // writeback stage
    logic wb_fw;
    assign wb_fw = r_mw_valid && r_mw_rw && (r_mw_dest != 5'd0);

    function automatic logic [31:0] rf_read(input logic [4:0] a, input logic fw,
                                            input logic [4:0] wr, input logic [31:0] wv,
                                            input logic [31:0] q);
        if (a == 5'd0) return 32'd0;
        if (fw && wr == a) return wv;
        return q;
    endfunction

    // memory stage, store data takes a matching writeback value
    logic [31:0] m_data, m_res;
    logic        m_store;
    assign m_data  = (wb_fw && r_mw_dest == r_xm_rt) ? r_mw_value : r_xm_data;
    assign m_res   = r_xm_rd ? pf_data : r_xm_alu;
    assign m_store = r_xm_valid && r_xm_wr;

    // execute stage with forwarding from ex/mem then mem/wb
    logic        ex_fw;
    logic [31:0] e_a, e_b, e_r;
    assign ex_fw = r_xm_valid && r_xm_rw && !r_xm_rd && (r_xm_dest != 5'd0);

    always_comb begin
        if (ex_fw && r_xm_dest == r_ex_rs)              e_a = r_xm_alu;
        else if (wb_fw && r_mw_dest == r_ex_rs)         e_a = r_mw_value;
        else                                            e_a = r_ex_a;
        if (ex_fw && r_xm_dest == r_ex_rt)              e_b = r_xm_alu;
        else if (wb_fw && r_mw_dest == r_ex_rt)         e_b = r_mw_value;
        else                                            e_b = r_ex_b;
        if (r_ex_ctrl.br)                               e_r = 32'd0;
        else if (r_ex_ctrl.imm)                         e_r = e_a + sext16(r_ex_imm);
        else if (r_ex_ctrl.add)                         e_r = e_a + e_b;
        else                                            e_r = e_a - e_b;
    end

    // decode and hazard detection
    logic [5:0]  d_op;
    logic [4:0]  d_rs, d_rt;
    logic [31:0] d_va, d_vb, d_target;
    logic        d_uses_rs, d_stall, d_taken;
    t_ctrl       d_ctrl;
    logic [4:0]  d_dest;

    assign d_op  = r_if_instr[31:26];
    assign d_rs  = r_if_instr[25:21];
    assign d_rt  = r_if_instr[20:16];
    assign d_va  = rf_read(d_rs, wb_fw, r_mw_dest, r_mw_value, r_rf[d_rs]);
    assign d_vb  = rf_read(d_rt, wb_fw, r_mw_dest, r_mw_value, r_rf[d_rt]);
    assign d_uses_rs = (d_op == OP_RTYPE) || (d_op == OP_LW) || (d_op == OP_SW);
    assign d_stall = r_if_valid && r_ex_valid && r_ex_ctrl.rd &&
                     ((d_uses_rs && r_ex_dest == d_rs) ||
                      (d_op == OP_RTYPE && r_ex_dest == d_rt));
    assign d_target = r_pc + (sext16(r_if_instr[15:0]) << 2);

    always_comb begin
        d_ctrl  = '0;
        d_dest  = 5'd0;
        d_taken = 1'b0;
        unique case (d_op)
            OP_RTYPE: begin
                d_ctrl.rw  = 1'b1;
                d_ctrl.add = (r_if_instr[5:0] == FUNCT_ADD);
                d_dest     = r_if_instr[15:11];
            end
            OP_LW: begin
                d_ctrl = '{rw: 1'b1, rd: 1'b1, wr: 1'b0, imm: 1'b1, add: 1'b1, br: 1'b0};
                d_dest = d_rt;
            end
            OP_SW: begin
                d_ctrl = '{rw: 1'b0, rd: 1'b0, wr: 1'b1, imm: 1'b1, add: 1'b1, br: 1'b0};
                d_dest = d_rt;
            end
            OP_BEQ: begin
                d_ctrl.br = 1'b1;
                d_taken   = r_if_valid && !d_stall && (d_va == d_vb);
            end
            default: ;
        endcase
    end

    // fetch and next state of the front end
    logic [31:0] n_pc;
    logic        n_fetch_en, n_if_valid, n_flush, n_fin, n_ex_valid;
    always_comb begin
        n_pc       = r_pc;
        n_fetch_en = r_fetch_en;
        n_if_valid = r_if_valid;
        n_flush    = 1'b0;
        if (!d_stall) begin
            if (d_taken) begin
                n_flush    = r_fetch_en;
                n_pc       = d_target;
                n_fetch_en = 1'b1;
                n_if_valid = 1'b0;
            end else if (r_fetch_en) begin
                if (i_instr_word == HALT_WORD) begin
                    n_fetch_en = 1'b0;
                    n_if_valid = 1'b0;
                end else begin
                    n_if_valid = 1'b1;
                    n_pc       = r_pc + 32'd4;
                end
            end else begin
                n_if_valid = 1'b0;
            end
        end
        n_ex_valid = !d_stall && r_if_valid;
        n_fin = !n_fetch_en && !n_if_valid && !n_ex_valid && !r_ex_valid && !r_xm_valid;
    end

    logic cur_fin, idx_reg_ok, idx_mem_ok;
    assign cur_fin = !r_fetch_en && !r_if_valid && !r_ex_valid && !r_xm_valid && !r_mw_valid;
    assign idx_reg_ok = (i_index < 8'd32);
    assign idx_mem_ok = ({24'd0, i_index} < 32'(DATA_WORDS));

    // data memory requests
    always_comb begin
        dm_req         = '0;
        dm_req.pf_load = step;
        dm_req.pf_word = e_r[DW_AW+1:2];
        dm_req.rb_en   = accept && (act == ACT_RD_MEM);
        dm_req.rb_word = DW_AW'(i_index);
        if (step && m_store) begin
            dm_req.wr_en   = 1'b1;
            dm_req.wr_word = r_xm_alu[DW_AW+1:2];
            dm_req.wr_data = m_data;
        end else if (accept && act == ACT_WR_MEM && idx_mem_ok) begin
            dm_req.wr_en   = 1'b1;
            dm_req.wr_word = DW_AW'(i_index);
            dm_req.wr_data = i_value;
        end
    end

    fsp_dmem u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (dm_req),
        .o_pf_data (pf_data),
        .o_rb_data (rb_data),
        .o_busy    (dm_busy)
    );

    // register file, register zero is never written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 32; k++) r_rf[k] <= '0;
        end else if (step && wb_fw) begin
            r_rf[r_mw_dest] <= r_mw_value;
        end else if (accept && act == ACT_WR_REG && idx_reg_ok && i_index != 8'd0) begin
            r_rf[i_index[4:0]] <= i_value;
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= '0;
            r_fetch_en <= 1'b1;
            r_if_instr <= '0;
            r_if_valid <= 1'b0;
            r_ex_valid <= 1'b0;
            r_ex_rs    <= '0;
            r_ex_rt    <= '0;
            r_ex_dest  <= '0;
            r_ex_imm   <= '0;
            r_ex_a     <= '0;
            r_ex_b     <= '0;
            r_ex_ctrl  <= '0;
            r_xm_valid <= 1'b0;
            r_xm_alu   <= '0;
            r_xm_data  <= '0;
            r_xm_dest  <= '0;
            r_xm_rt    <= '0;
            r_xm_rw    <= 1'b0;
            r_xm_rd    <= 1'b0;
            r_xm_wr    <= 1'b0;
            r_mw_valid <= 1'b0;
            r_mw_rw    <= 1'b0;
            r_mw_dest  <= '0;
            r_mw_value <= '0;
        end else if (step) begin
            r_pc       <= n_pc;
            r_fetch_en <= n_fetch_en;
            r_if_valid <= n_if_valid;
            if (!d_stall && !d_taken && r_fetch_en && i_instr_word != HALT_WORD) begin
                r_if_instr <= i_instr_word;
            end
            r_ex_valid <= n_ex_valid;
            if (n_ex_valid) begin
                r_ex_rs   <= d_rs;
                r_ex_rt   <= d_rt;
                r_ex_dest <= d_dest;
                r_ex_imm  <= r_if_instr[15:0];
                r_ex_a    <= d_va;
                r_ex_b    <= d_vb;
                r_ex_ctrl <= d_ctrl;
            end
            r_xm_valid <= r_ex_valid;
            r_xm_alu   <= r_ex_valid ? e_r : 32'd0;
            r_xm_data  <= r_ex_valid ? e_b : 32'd0;
            r_xm_dest  <= r_ex_valid ? r_ex_dest : 5'd0;
            r_xm_rt    <= r_ex_valid ? r_ex_rt : 5'd0;
            r_xm_rw    <= r_ex_valid && r_ex_ctrl.rw;
            r_xm_rd    <= r_ex_valid && r_ex_ctrl.rd;
            r_xm_wr    <= r_ex_valid && r_ex_ctrl.wr;
            r_mw_valid <= r_xm_valid;
            r_mw_rw    <= r_xm_valid && r_xm_rw;
            r_mw_dest  <= r_xm_valid ? r_xm_dest : 5'd0;
            r_mw_value <= r_xm_valid ? m_res : 32'd0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (accept) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_o_rd_mem <= (act == ACT_RD_MEM) && idx_mem_ok;
            r_o_read   <= (act == ACT_RD_REG && idx_reg_ok) ? r_rf[i_index[4:0]] : 32'd0;
            r_o_wbv    <= step && wb_fw;
            r_o_wbr    <= (step && wb_fw) ? r_mw_dest : 5'd0;
            r_o_wbd    <= (step && wb_fw) ? r_mw_value : 32'd0;
            r_o_stv    <= step && m_store;
            r_o_sta    <= (step && m_store) ? r_xm_alu : 32'd0;
            r_o_std    <= (step && m_store) ? m_data : 32'd0;
            r_o_stall  <= step && d_stall;
            r_o_flush  <= step && n_flush;
            r_o_pc     <= step ? n_pc : r_pc;
            r_o_fin    <= step ? n_fin : cur_fin;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_fetch_address = r_o_pc;
    assign o_read_value    = r_o_rd_mem ? rb_data : r_o_read;
    assign o_wb_valid      = r_o_wbv;
    assign o_wb_register   = r_o_wbr;
    assign o_wb_value      = r_o_wbd;
    assign o_store_valid   = r_o_stv;
    assign o_store_address = r_o_sta;
    assign o_store_value   = r_o_std;
    assign o_stalled       = r_o_stall;
    assign o_flushed       = r_o_flush;
    assign o_finished      = r_o_fin;

    // checks
    a_wb_not_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_wb_valid |-> o_wb_register != 5'd0)
        else $error("writeback reported for register zero");

    a_no_beat_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dm_busy |-> !o_ready)
        else $error("beat accepted during memory clear");

    a_finished_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_finished |-> !o_stalled && !o_flushed)
        else $error("finished with stall or flush");

endmodule

>>> bench/tb_five_stage_pipeline_core_unit.sv
// ----------------------------------------------------------------------------
// tb_five_stage_pipeline_core_unit
// self-checking bench for the five-stage pipeline core unit
// ----------------------------------------------------------------------------
// a directed table covers preload and readback extremes, forwarding, a
// load-use stall, a taken branch that throws away a halt word and unknown
// opcodes; a random instruction stream with random preloads and readbacks
// follows, and halt words drain the core at the end. every beat is run
// through a cycle-level model of the core and each result beat is compared
// field by field with the oldest prediction. the sender idles in bursts and
// the receiver stalls on a rotating pattern
// ----------------------------------------------------------------------------
module tb_five_stage_pipeline_core_unit;
    import fsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         N_RANDOM  = 650;
    localparam int         WD_LIMIT  = 3000;
    localparam logic [5:0] FUNCT_SUB = 6'd34;

    // one result beat, fields in port order
    typedef struct packed {
        logic [31:0] fetch_address;
        logic [31:0] read_value;
        logic        wb_valid;
        logic [4:0]  wb_register;
        logic [31:0] wb_value;
        logic        store_valid;
        logic [31:0] store_address;
        logic [31:0] store_value;
        logic        stalled;
        logic        flushed;
        logic        finished;
    } t_core_res;

    // directed row: typed read_value only where it is obvious
    typedef struct packed {
        logic [2:0]  act;
        logic [31:0] iw;
        logic [7:0]  idx;
        logic [31:0] val;
        logic        chk;
        logic [31:0] rd;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_action = '0;
    logic [31:0] i_instr_word = '0;
    logic [7:0]  i_index = '0;
    logic [31:0] i_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_fetch_address;
    logic [31:0] o_read_value;
    logic        o_wb_valid;
    logic [4:0]  o_wb_register;
    logic [31:0] o_wb_value;
    logic        o_store_valid;
    logic [31:0] o_store_address;
    logic [31:0] o_store_value;
    logic        o_stalled;
    logic        o_flushed;
    logic        o_finished;

    five_stage_pipeline_core_unit u_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // pipeline model state
    // ------------------------------------------------------------------
    logic [31:0] pc;
    logic        fetch_on;
    logic [31:0] fd_instr;
    logic        fd_valid;
    logic        de_valid;
    logic [4:0]  de_rs, de_rt, de_dest;
    logic [15:0] de_imm;
    logic [31:0] de_a, de_b;
    t_ctrl       de_ctrl;
    logic        em_valid, em_rw, em_rd, em_wr;
    logic [4:0]  em_dest, em_rt;
    logic [31:0] em_alu, em_data;
    logic        mw_valid, mw_rw;
    logic [4:0]  mw_dest;
    logic [31:0] mw_value;
    logic [31:0] rf [32];
    logic [31:0] dm [DATA_WORDS];

    t_core_res   expected_q[$];
    int          mismatches = 0;
    int          burst_left = 0;

    function automatic logic core_drained();
        return !fetch_on && !fd_valid && !de_valid && !em_valid && !mw_valid;
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // advance the model by one beat and return the result it causes
    task automatic run_core_beat(input logic [2:0] act, input logic [31:0] iw,
                                 input logic [7:0] idx, input logic [31:0] val,
                                 output t_core_res r);
        logic            wb_fw, ex_fw, stall, taken, uses_rs, n_mw_valid, n_em_valid;
        logic [31:0]     sdata, res, a, b, alu, target;
        logic [DW_AW-1:0] word;
        logic [5:0]      op;
        logic [4:0]      rs_i, rt_i, d;
        t_ctrl           c;
        logic            n_mw_rw;
        logic [4:0]      n_mw_dest;
        logic [31:0]     n_mw_value;
        logic            n_em_rw, n_em_rd, n_em_wr;
        logic [4:0]      n_em_dest, n_em_rt;
        logic [31:0]     n_em_alu, n_em_data;
        r = '0;
        if (act != ACT_STEP) begin
            if (act == ACT_WR_REG && idx < 32 && idx != 0) rf[idx[4:0]] = val;
            else if (act == ACT_WR_MEM && idx < DATA_WORDS) dm[idx] = val;
            else if (act == ACT_RD_REG && idx < 32) r.read_value = rf[idx[4:0]];
            else if (act == ACT_RD_MEM && idx < DATA_WORDS) r.read_value = dm[idx];
        end else begin
            // writeback lands before decode reads the register file
            wb_fw = mw_valid && mw_rw && mw_dest != 0;
            if (wb_fw) begin
                rf[mw_dest] = mw_value;
                r.wb_valid = 1'b1;
                r.wb_register = mw_dest;
                r.wb_value = mw_value;
            end
            // memory stage, writeback value forwarded into store data
            n_mw_valid = 1'b0; n_mw_rw = 1'b0; n_mw_dest = '0; n_mw_value = '0;
            if (em_valid) begin
                word = em_alu[DW_AW+1:2];
                sdata = (wb_fw && mw_dest == em_rt) ? mw_value : em_data;
                res = em_rd ? dm[word] : em_alu;
                if (em_wr) begin
                    dm[word] = sdata;
                    r.store_valid = 1'b1;
                    r.store_address = em_alu;
                    r.store_value = sdata;
                end
                n_mw_valid = 1'b1; n_mw_rw = em_rw; n_mw_dest = em_dest; n_mw_value = res;
            end
            // execute with forwarding, ex/mem first
            n_em_valid = 1'b0; n_em_rw = 1'b0; n_em_rd = 1'b0; n_em_wr = 1'b0;
            n_em_dest = '0; n_em_rt = '0; n_em_alu = '0; n_em_data = '0;
            if (de_valid) begin
                ex_fw = em_valid && em_rw && !em_rd && em_dest != 0;
                a = de_a;
                b = de_b;
                if (ex_fw && em_dest == de_rs) a = em_alu;
                else if (wb_fw && mw_dest == de_rs) a = mw_value;
                if (ex_fw && em_dest == de_rt) b = em_alu;
                else if (wb_fw && mw_dest == de_rt) b = mw_value;
                if (de_ctrl.imm) alu = a + sx16(de_imm);
                else if (de_ctrl.add) alu = a + b;
                else alu = a - b;
                if (de_ctrl.br) alu = '0;
                n_em_valid = 1'b1; n_em_rw = de_ctrl.rw; n_em_rd = de_ctrl.rd;
                n_em_wr = de_ctrl.wr; n_em_dest = de_dest; n_em_rt = de_rt;
                n_em_alu = alu; n_em_data = b;
            end
            // decode and load-use detection
            op = fd_instr[31:26];
            rs_i = fd_instr[25:21];
            rt_i = fd_instr[20:16];
            uses_rs = op == OP_RTYPE || op == OP_LW || op == OP_SW;
            stall = fd_valid && de_valid && de_ctrl.rd &&
                    ((uses_rs && de_dest == rs_i) || (op == OP_RTYPE && de_dest == rt_i));
            taken = 1'b0;
            target = '0;
            if (stall) begin
                de_valid = 1'b0;
            end else if (fd_valid) begin
                c = '0;
                d = '0;
                case (op)
                    OP_RTYPE: begin
                        c.rw = 1'b1;
                        c.add = fd_instr[5:0] == FUNCT_ADD;
                        d = fd_instr[15:11];
                    end
                    OP_LW: begin
                        c.rw = 1'b1; c.rd = 1'b1; c.imm = 1'b1; c.add = 1'b1;
                        d = rt_i;
                    end
                    OP_SW: begin
                        c.wr = 1'b1; c.imm = 1'b1; c.add = 1'b1;
                        d = rt_i;
                    end
                    OP_BEQ: begin
                        c.br = 1'b1;
                        taken = rf[rs_i] == rf[rt_i];
                        target = pc + (sx16(fd_instr[15:0]) << 2);
                    end
                    default: ;
                endcase
                de_valid = 1'b1;
                de_rs = rs_i;
                de_rt = rt_i;
                de_dest = d;
                de_imm = fd_instr[15:0];
                de_a = rf[rs_i];
                de_b = rf[rt_i];
                de_ctrl = c;
            end else begin
                de_valid = 1'b0;
            end
            // fetch
            if (!stall) begin
                if (taken) begin
                    r.flushed = fetch_on;
                    pc = target;
                    fetch_on = 1'b1;
                    fd_valid = 1'b0;
                end else if (fetch_on) begin
                    if (iw == HALT_WORD) begin
                        fetch_on = 1'b0;
                        fd_valid = 1'b0;
                    end else begin
                        fd_instr = iw;
                        fd_valid = 1'b1;
                        pc = pc + 32'd4;
                    end
                end else begin
                    fd_valid = 1'b0;
                end
            end
            em_valid = n_em_valid; em_rw = n_em_rw; em_rd = n_em_rd; em_wr = n_em_wr;
            em_dest = n_em_dest; em_rt = n_em_rt; em_alu = n_em_alu; em_data = n_em_data;
            mw_valid = n_mw_valid; mw_rw = n_mw_rw; mw_dest = n_mw_dest;
            mw_value = n_mw_value;
            r.stalled = stall;
        end
        r.fetch_address = pc;
        r.finished = core_drained();
    endtask

    // ------------------------------------------------------------------
    // instruction encoders and random stream
    // ------------------------------------------------------------------
    function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                          input logic [4:0] rd, input logic [5:0] fn);
        return {OP_RTYPE, rs, rt, rd, 5'd0, fn};
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // narrow register set most of the time so hazards are frequent
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
    endfunction

    function automatic logic [31:0] random_instr();
        int          pick;
        logic [15:0] imm;
        logic [5:0]  fn;
        logic [31:0] w;
        pick = $urandom_range(0, 99);
        imm = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15) * 4);
        fn = 6'($urandom);
        if (fn == FUNCT_ADD) fn = FUNCT_SUB;
        if (pick < 25)
            w = enc_r(pick_reg(), pick_reg(), pick_reg(), FUNCT_ADD);
        else if (pick < 35)
            w = enc_r(pick_reg(), pick_reg(), pick_reg(), fn) | ($urandom & 32'h7C0);
        else if (pick < 55)
            w = enc_i(OP_LW, pick_reg(), pick_reg(), imm);
        else if (pick < 70)
            w = enc_i(OP_SW, pick_reg(), pick_reg(), imm);
        else if (pick < 85)
            w = enc_i(OP_BEQ, pick_reg(), pick_reg(),
                      ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 8) - 4));
        else if (pick < 92)
            w = enc_i(6'($urandom), pick_reg(), pick_reg(), 16'($urandom));
        else
            w = $urandom;
        // a halt would stop the core for good, keep it for the end
        if (w == HALT_WORD) w[0] = 1'b0;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // sender: one beat, idling in bursts; valid stays up across beats
    // ------------------------------------------------------------------
    task automatic send_beat(input t_row row);
        t_core_res r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_action <= row.act;
        i_instr_word <= row.iw;
        i_index <= row.idx;
        i_value <= row.val;
        do @(posedge i_clk); while (!o_ready);
        run_core_beat(row.act, row.iw, row.idx, row.val, r);
        if (row.chk) r.read_value = row.rd;
        expected_q.push_back(r);
    endtask

    t_row plan [24];

    initial begin
        t_row row;
        int   pick;
        pc = '0; fetch_on = 1'b1; fd_instr = '0; fd_valid = 1'b0; de_valid = 1'b0;
        de_rs = '0; de_rt = '0; de_dest = '0; de_imm = '0; de_a = '0; de_b = '0;
        de_ctrl = '0; em_valid = 1'b0; em_rw = 1'b0; em_rd = 1'b0; em_wr = 1'b0;
        em_dest = '0; em_rt = '0; em_alu = '0; em_data = '0;
        mw_valid = 1'b0; mw_rw = 1'b0; mw_dest = '0; mw_value = '0;
        foreach (rf[k]) rf[k] = '0;
        foreach (dm[k]) dm[k] = '0;

        //          act         iw                                   idx    val          chk rd
        plan[0]  = '{ACT_RD_MEM, 32'h0, 8'd0, 32'h0, 1'b1, 32'h0};   // memory cleared
        plan[1]  = '{ACT_WR_REG, 32'h0, 8'd1, 32'hFFFF_FFFF, 1'b0, 32'h0};
        plan[2]  = '{ACT_WR_REG, 32'h0, 8'd2, 32'h1, 1'b0, 32'h0};
        plan[3]  = '{ACT_WR_REG, 32'h0, 8'd31, 32'h8000_0000, 1'b0, 32'h0};
        plan[4]  = '{ACT_WR_REG, 32'h0, 8'd0, 32'h1234, 1'b0, 32'h0};    // dropped
        plan[5]  = '{ACT_RD_REG, 32'h0, 8'd0, 32'h0, 1'b1, 32'h0};
        plan[6]  = '{ACT_RD_REG, 32'h0, 8'd1, 32'h0, 1'b1, 32'hFFFF_FFFF};
        plan[7]  = '{ACT_RD_REG, 32'h0, 8'd255, 32'h0, 1'b1, 32'h0};     // out of range
        plan[8]  = '{ACT_WR_MEM, 32'h0, 8'd255, 32'hA5A5_A5A5, 1'b0, 32'h0};
        plan[9]  = '{ACT_RD_MEM, 32'h0, 8'd255, 32'h0, 1'b1, 32'hA5A5_A5A5};
        plan[10] = '{3'd7, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF, 1'b1, 32'h0};
        plan[11] = '{ACT_STEP, enc_r(5'd1, 5'd2, 5'd3, FUNCT_ADD), 8'd0, 32'h0, 1'b0, 32'h0};
        plan[12] = '{ACT_STEP, enc_r(5'd3, 5'd1, 5'd4, FUNCT_SUB), 8'd0, 32'h0, 1'b0, 32'h0};
        plan[13] = '{ACT_STEP, enc_i(OP_SW, 5'd0, 5'd4, 16'd8), 8'd0, 32'h0, 1'b0, 32'h0};
        plan[14] = '{ACT_STEP, enc_i(OP_LW, 5'd0, 5'd5, 16'd8), 8'd0, 32'h0, 1'b0, 32'h0};
        // load-use: the dependent add is held in decode behind the load
        plan[15] = '{ACT_STEP, enc_r(5'd5, 5'd5, 5'd6, FUNCT_ADD), 8'd0, 32'h0, 1'b0, 32'h0};
        plan[16] = '{ACT_STEP, enc_r(5'd5, 5'd5, 5'd6, FUNCT_ADD), 8'd0, 32'h0, 1'b0, 32'h0};
        plan[17] = '{ACT_STEP, enc_i(OP_LW, 5'd31, 5'd7, 16'hFFFC), 8'd0, 32'h0, 1'b0, 32'h0};
        plan[18] = '{ACT_STEP, 32'hFC00_0000, 8'd0, 32'h0, 1'b0, 32'h0};   // unknown opcode
        // taken branch in decode throws away the halt fetched with it
        plan[19] = '{ACT_STEP, enc_i(OP_BEQ, 5'd0, 5'd0, 16'd2), 8'd0, 32'h0, 1'b0, 32'h0};
        plan[20] = '{ACT_STEP, HALT_WORD, 8'd0, 32'h0, 1'b0, 32'h0};
        plan[21] = '{ACT_STEP, enc_i(OP_SW, 5'd2, 5'd1, 16'hFFFC), 8'd0, 32'h0, 1'b0, 32'h0};
        plan[22] = '{ACT_STEP, 32'h0, 8'd0, 32'h0, 1'b0, 32'h0};
        plan[23] = '{ACT_RD_MEM, 32'h0, 8'd2, 32'h0, 1'b0, 32'h0};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) send_beat(plan[k]);

        // hold off until every result of the directed part is back
        i_valid <= 1'b0;
        burst_left = $urandom_range(1, 40);
        do @(posedge i_clk); while (expected_q.size() != 0);

        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            row = '0;
            row.iw = $urandom;
            row.val = ($urandom_range(0, 5) == 0) ? '1 : $urandom;
            row.idx = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
            if (pick < 84) begin
                row.act = ACT_STEP;
                row.iw = random_instr();
            end else if (pick < 97) begin
                row.act = 3'($urandom_range(ACT_WR_REG, ACT_RD_MEM));
            end else begin
                row.act = 3'($urandom_range(5, 7));
            end
            send_beat(row);
        end

        // feed halt words until the core has drained
        for (int n = 0; n < 64 && !core_drained(); n++)
            send_beat(t_row'{ACT_STEP, HALT_WORD, 8'd0, 32'h0, 1'b0, 32'h0});
        send_beat(t_row'{ACT_RD_REG, 32'h0, 8'd3, 32'h0, 1'b0, 32'h0});

        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: stalls on a rotating 16-bit pattern, with ready stretches
    // ------------------------------------------------------------------
    int          rx_stretch = 0;
    int          rx_mode = 0;
    int          rx_phase = 0;
    logic [15:0] rx_pattern = 16'hFFFF;

    always @(posedge i_clk) begin
        if (rx_stretch == 0) begin
            rx_stretch = $urandom_range(10, 80);
            rx_mode = $urandom_range(0, 2);
            rx_pattern = 16'($urandom) | 16'h1;
        end
        rx_stretch--;
        rx_phase++;
        i_ready <= (rx_mode == 0) ? 1'b1 : rx_pattern[rx_phase % 16];
    end

    // ------------------------------------------------------------------
    // result check against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_core_res got, exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_fetch_address, o_read_value, o_wb_valid, o_wb_register, o_wb_value,
                   o_store_valid, o_store_address, o_store_value, o_stalled, o_flushed,
                   o_finished};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", got);
            end else begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch at %0t", $realtime);
                        $display("  fetch_address exp %h got %h", exp_r.fetch_address,
                                 got.fetch_address);
                        $display("  read_value    exp %h got %h", exp_r.read_value,
                                 got.read_value);
                        $display("  wb            exp %b/%0d/%h got %b/%0d/%h",
                                 exp_r.wb_valid, exp_r.wb_register, exp_r.wb_value,
                                 got.wb_valid, got.wb_register, got.wb_value);
                        $display("  store         exp %b/%h/%h got %b/%h/%h",
                                 exp_r.store_valid, exp_r.store_address, exp_r.store_value,
                                 got.store_valid, got.store_address, got.store_value);
                        $display("  stall/flush/fin exp %b%b%b got %b%b%b",
                                 exp_r.stalled, exp_r.flushed, exp_r.finished,
                                 got.stalled, got.flushed, got.finished);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: cycles with no beat on either side
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
